FILE: hw/rtl/slsfl_pkg.sv
// Shared types, constants and the status decode for the sync/length/sum frame link.
// No dependencies; used by slsfl_rx_parser and sync_length_sum_frame_link_unit.
package slsfl_pkg;

   localparam logic [7:0] FRAME_SYNC   = 8'h55;
   localparam int         MAX_PAYLOAD  = 15;
   localparam int         LEN_OVERHEAD = 4;   // sync, command, length, checksum
   localparam int         STATUS_LEN   = 2;
   localparam logic [7:0] STATUS_CMD   = 8'h00;
   localparam logic [7:0] ACTION_CMD   = 8'h01;
   localparam logic [7:0] ACTION_LEN   = 8'h01;
   localparam int         TX_BEATS     = 5;
   localparam int         TX_BEAT_W    = $clog2(TX_BEATS);

   typedef logic [TX_BEAT_W-1:0] beat_type;

   // request selector (req_tuser)
   localparam logic CMD_RX   = 1'b0;
   localparam logic CMD_SEND = 1'b1;

   // result kind (rsp_tuser)
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_TX     = 1'b1;

   // cover position codes
   localparam logic [2:0] POS_OPEN     = 3'd0;
   localparam logic [2:0] POS_SHUT     = 3'd1;
   localparam logic [2:0] POS_RISING   = 3'd2;
   localparam logic [2:0] POS_LOWERING = 3'd3;
   localparam logic [2:0] POS_HALTED   = 3'd4;

   localparam logic [7:0] MOVE_MASK    = 8'h60;
   localparam logic [7:0] MOVE_OPENING = 8'h40;
   localparam logic [7:0] MOVE_CLOSING = 8'h60;

   typedef struct packed {
      logic       prewarn;
      logic       venting;
      logic       error_flag;
      logic       light_on;
      logic       aux_relay;
      logic [2:0] cover_state;
   } door_status_type;

   typedef struct packed {
      logic            hit;     // current byte closes a good status frame
      door_status_type status;
   } parse_result_type;

   function automatic door_status_type decode_status(input logic [7:0] p0,
                                                     input logic [7:0] p1);
      door_status_type st;
      if (p0[0]) begin
         st.cover_state = POS_OPEN;
      end else if (p0[1]) begin
         st.cover_state = POS_SHUT;
      end else if ((p0 & MOVE_MASK) == MOVE_OPENING) begin
         st.cover_state = POS_RISING;
      end else if ((p0 & MOVE_MASK) == MOVE_CLOSING) begin
         st.cover_state = POS_LOWERING;
      end else begin
         st.cover_state = POS_HALTED;
      end
      st.aux_relay  = p0[2];
      st.light_on   = p0[3];
      st.error_flag = p0[4];
      st.venting    = p0[7];
      st.prewarn    = p1[0];
      return st;
   endfunction

endpackage

FILE: hw/rtl/slsfl_rx_parser.sv
// Receive side frame tracker: sync hunt, length check, running checksum.
// Depends on slsfl_pkg. State advances only on take.
module slsfl_rx_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [7:0]                  rx_byte,
   output slsfl_pkg::parse_result_type result
);

   logic [4:0] count_ff, count_in;
   logic [4:0] len_ff, len_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] cmd_byte_ff, p0_ff, p1_ff;   // frame bytes 1, 3 and 4
   logic [4:0] count_nx;
   logic       hit;

   assign count_nx = count_ff + 5'd1;

   always_comb begin
      count_in = count_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      hit      = 1'b0;
      if (count_ff == 5'd0) begin
         if (rx_byte == slsfl_pkg::FRAME_SYNC) begin
            count_in = 5'd1;
            len_in   = 5'd0;
            sum_in   = slsfl_pkg::FRAME_SYNC;
         end
      end else if (count_nx == 5'd3) begin
         // length byte
         if (rx_byte <= 8'(slsfl_pkg::MAX_PAYLOAD)) begin
            len_in   = rx_byte[4:0] + 5'(slsfl_pkg::LEN_OVERHEAD);
            sum_in   = sum_ff + rx_byte;
            count_in = count_nx;
         end else begin
            count_in = 5'd0;
         end
      end else if (count_nx == len_ff) begin
         // checksum byte closes the frame
         count_in = 5'd0;
         hit = (sum_ff == rx_byte) && (cmd_byte_ff == slsfl_pkg::STATUS_CMD) &&
               (len_ff == 5'(slsfl_pkg::STATUS_LEN + slsfl_pkg::LEN_OVERHEAD));
      end else begin
         sum_in   = sum_ff + rx_byte;
         count_in = count_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 5'd0;
         len_ff   <= 5'd0;
         sum_ff   <= 8'd0;
      end else if (take) begin
         count_ff <= count_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
      end
   end

   // frame byte capture, no reset: always written before use
   always_ff @(posedge clock) begin
      if (take) begin
         if (count_ff == 5'd1) cmd_byte_ff <= rx_byte;
         if (count_ff == 5'd3) p0_ff       <= rx_byte;
         if (count_ff == 5'd4) p1_ff       <= rx_byte;
      end
   end

   assign result.hit    = hit;
   assign result.status = slsfl_pkg::decode_status(p0_ff, p1_ff);

endmodule

FILE: hw/rtl/sync_length_sum_frame_link_unit.sv
// Frame link top level: input register, receive parser, action frame sender,
// output register. Depends on slsfl_pkg and slsfl_rx_parser.
//
//  channel | dir | tdata (low bit up)                                | tuser   | tlast
//  req     | in  | rx_byte[7:0], action_code[15:8]                   | command | -
//  rsp     | out | tx_byte[7:0], cover_state[10:8], aux_relay,        | kind    | tx_last
//          |     | light_on, error_flag, venting, prewarn, status_valid[16], zero
//
// A transaction is registered on acceptance and handled from the input register;
// its result is loaded into the output register unless rsp stalls. Received
// bytes can arrive back to back. A send request holds the input register until
// all five bytes of its action frame have been emitted.
// Reset (synchronous) clears the frame tracker, the byte counter and both valid flags.
// A stall on rsp holds the output register; req_tready is low while a send still
// has bytes to emit or while a result cannot move on.
module sync_length_sum_frame_link_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte[7:0], action_code[15:8]
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tx_byte[7:0], cover_state[10:8], aux_relay[11],
                                    // light_on[12], error_flag[13], venting[14],
                                    // prewarn[15], status_valid[16], zero[23:17]
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // tx_last
);

   logic        in_valid_ff, in_valid_in;
   logic        in_cmd_ff;
   logic [7:0]  in_rx_ff, in_act_ff;
   slsfl_pkg::beat_type beat_ff, beat_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic        rsp_last_ff;
   logic [7:0]  rsp_byte_ff;
   logic [7:0]  rsp_stat_ff;
   logic        rsp_seen_ff;

   slsfl_pkg::parse_result_type parse;
   logic        out_free, is_send, last_beat, parse_take, in_done, out_load;
   logic [7:0]  tx_byte;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign is_send   = (in_cmd_ff == slsfl_pkg::CMD_SEND);
   assign last_beat = (beat_ff == slsfl_pkg::beat_type'(slsfl_pkg::TX_BEATS - 1));

   assign parse_take = in_valid_ff && !is_send && (!parse.hit || out_free);
   assign in_done    = parse_take || (in_valid_ff && is_send && out_free && last_beat);
   assign req_tready = !in_valid_ff || in_done;
   assign out_load   = in_valid_ff && out_free && (is_send || parse.hit);

   slsfl_rx_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (parse_take),
      .rx_byte (in_rx_ff),
      .result  (parse)
   );

   always_comb begin
      case (beat_ff)
         slsfl_pkg::beat_type'(0): tx_byte = slsfl_pkg::FRAME_SYNC;
         slsfl_pkg::beat_type'(1): tx_byte = slsfl_pkg::ACTION_CMD;
         slsfl_pkg::beat_type'(2): tx_byte = slsfl_pkg::ACTION_LEN;
         slsfl_pkg::beat_type'(3): tx_byte = in_act_ff;
         default:    tx_byte = slsfl_pkg::FRAME_SYNC + slsfl_pkg::ACTION_CMD +
                               slsfl_pkg::ACTION_LEN + in_act_ff;
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (in_done) begin
         in_valid_in = 1'b0;
      end
      beat_in = beat_ff;
      if (in_valid_ff && is_send && out_free) begin
         beat_in = last_beat ? '0 : beat_ff + slsfl_pkg::beat_type'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff <= req_tuser;
         in_rx_ff  <= req_tdata[7:0];
         in_act_ff <= req_tdata[15:8];
      end
      if (out_load) begin
         if (is_send) begin
            rsp_kind_ff <= slsfl_pkg::KIND_TX;
            rsp_byte_ff <= tx_byte;
            rsp_last_ff <= last_beat;
            rsp_stat_ff <= 8'd0;
            rsp_seen_ff <= 1'b0;
         end else begin
            rsp_kind_ff <= slsfl_pkg::KIND_STATUS;
            rsp_byte_ff <= 8'd0;
            rsp_last_ff <= 1'b0;
            rsp_stat_ff <= parse.status;
            rsp_seen_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_seen_ff, rsp_stat_ff, rsp_byte_ff};

   // tx beat counter only runs for a send transaction in the input register
   a_beat_owner: assert property (@(posedge clock) disable iff (reset)
      (beat_ff != '0) |-> (in_valid_ff && is_send))
      else $error("beat counter active without send transaction");

   a_last_is_tx: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == slsfl_pkg::KIND_TX))
      else $error("tlast on a status result");

   a_status_seen: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == slsfl_pkg::KIND_STATUS) |-> rsp_tdata[16])
      else $error("status result without status_valid");

   a_send_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && is_send && !last_beat) |=> (in_valid_ff && is_send))
      else $error("send transaction left before its last byte");

endmodule

FILE: tb/tb_sync_length_sum_frame_link_unit.sv
// Self-checking testbench for sync_length_sum_frame_link_unit: streams received bytes and
// send requests, predicts status and transmit results, checks every rsp transaction.
// Depends on slsfl_pkg and the RTL of the frame link.
`timescale 1ns / 100ps

module tb_sync_length_sum_frame_link_unit;

   localparam int RANDOM_ITEMS = 230;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 20;

   typedef struct {
      logic        cmd;
      logic [7:0]  rx;
      logic [7:0]  act;
      int unsigned gap;
      bit          drain;   // hold off until every due result has arrived
   } link_item_type;

   typedef struct packed {
      logic                       kind;
      logic [7:0]                 tx_byte;
      logic                       tx_last;
      slsfl_pkg::door_status_type st;
      logic                       status_valid;
   } link_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // rx_byte[7:0], action_code[15:8]
   logic        req_tuser = 1'b0; // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // tx_byte[7:0], cover_state[10:8], aux_relay[11],
                                  // light_on[12], error_flag[13], venting[14],
                                  // prewarn[15], status_valid[16], zero[23:17]
   logic        rsp_tuser;        // kind
   logic        rsp_tlast;        // tx_last

   sync_length_sum_frame_link_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   link_item_type   stimulus_items[$];
   link_result_type responses_due[$];
   int              mismatch_count = 0;
   int              items_accepted = 0;
   int              results_seen = 0;
   int              cycle_count = 0;
   bit              quiet_run = 1'b0;
   bit              drain_next = 1'b0;

   // receiver state as the frame tracker sees it
   bit [4:0]                   frame_pos = '0;
   bit [4:0]                   frame_len = '0;
   bit [7:0]                   frame_sum = '0;
   bit [7:0]                   frame_buf[5] = '{default: 8'h00};
   slsfl_pkg::door_status_type last_status = '0;
   bit                         status_seen = 1'b0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: result %0d %s: got %0h, want %0h", $time, results_seen, what,
               got, want);
      mismatch_count++;
   endtask

   task automatic advance_frame_link(input link_item_type it);
      link_result_type r;
      logic [7:0]      p0;
      logic [7:0]      p1;
      r = '0;
      if (it.cmd == slsfl_pkg::CMD_SEND) begin
         r.kind = slsfl_pkg::KIND_TX;
         r.tx_byte = slsfl_pkg::FRAME_SYNC;
         responses_due.push_back(r);
         r.tx_byte = slsfl_pkg::ACTION_CMD;
         responses_due.push_back(r);
         r.tx_byte = slsfl_pkg::ACTION_LEN;
         responses_due.push_back(r);
         r.tx_byte = it.act;
         responses_due.push_back(r);
         r.tx_byte = slsfl_pkg::FRAME_SYNC + slsfl_pkg::ACTION_CMD + slsfl_pkg::ACTION_LEN +
                     it.act;
         r.tx_last = 1'b1;
         responses_due.push_back(r);
      end else if (frame_pos == 0) begin
         if (it.rx == slsfl_pkg::FRAME_SYNC) begin
            frame_buf[0] = it.rx;
            frame_pos = 5'd1;
            frame_len = 5'd0;
            frame_sum = it.rx;
         end
      end else begin
         if (frame_pos < 5) frame_buf[frame_pos[2:0]] = it.rx;
         frame_pos = frame_pos + 5'd1;
         if (frame_pos == 3) begin
            if (it.rx <= slsfl_pkg::MAX_PAYLOAD) begin
               frame_len = 5'(it.rx + slsfl_pkg::LEN_OVERHEAD);
               frame_sum = frame_sum + it.rx;
            end else begin
               frame_pos = 5'd0;
            end
         end else if (frame_pos == frame_len) begin
            frame_pos = 5'd0;
            if (frame_sum == it.rx && frame_buf[1] == slsfl_pkg::STATUS_CMD &&
                frame_buf[2] == slsfl_pkg::STATUS_LEN) begin
               p0 = frame_buf[3];
               p1 = frame_buf[4];
               if (p0[0]) begin
                  last_status.cover_state = slsfl_pkg::POS_OPEN;
               end else if (p0[1]) begin
                  last_status.cover_state = slsfl_pkg::POS_SHUT;
               end else if (p0[6:5] == 2'b10) begin
                  last_status.cover_state = slsfl_pkg::POS_RISING;
               end else if (p0[6:5] == 2'b11) begin
                  last_status.cover_state = slsfl_pkg::POS_LOWERING;
               end else begin
                  last_status.cover_state = slsfl_pkg::POS_HALTED;
               end
               last_status.aux_relay  = p0[2];
               last_status.light_on   = p0[3];
               last_status.error_flag = p0[4];
               last_status.venting    = p0[7];
               last_status.prewarn    = p1[0];
               status_seen = 1'b1;
               r.kind = slsfl_pkg::KIND_STATUS;
               r.st = last_status;
               r.status_valid = status_seen;
               responses_due.push_back(r);
            end
         end else begin
            frame_sum = frame_sum + it.rx;
         end
      end
   endtask

   task automatic push_item(input logic cmd, input logic [7:0] rx, input logic [7:0] act);
      link_item_type it;
      it.cmd = cmd;
      it.rx = rx;
      it.act = act;
      it.gap = quiet_run ? 0 : $urandom_range(0, 6);
      it.drain = drain_next;
      drain_next = 1'b0;
      stimulus_items.push_back(it);
   endtask

   task automatic push_rx(input logic [7:0] b);
      push_item(slsfl_pkg::CMD_RX, b, 8'($urandom_range(0, 255)));
   endtask

   task automatic push_send(input logic [7:0] a);
      push_item(slsfl_pkg::CMD_SEND, 8'($urandom_range(0, 255)), a);
   endtask

   // sync, command, length, payload, checksum; stops after the length byte if too long.
   // send_at places a send request in front of that byte of the frame.
   task automatic queue_frame(input logic [7:0] cmd_b, input logic [7:0] len_b,
                              input logic [7:0] p0, input logic [7:0] p1,
                              input bit bad_sum, input int send_at);
      logic [7:0] bytes[$];
      logic [7:0] sum;
      int         k;
      bytes = {slsfl_pkg::FRAME_SYNC, cmd_b, len_b};
      if (len_b <= slsfl_pkg::MAX_PAYLOAD) begin
         for (k = 0; k < len_b; k++) begin
            bytes.push_back(k == 0 ? p0 : k == 1 ? p1 : 8'($urandom_range(0, 255)));
         end
         sum = '0;
         foreach (bytes[i]) sum = sum + bytes[i];
         if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
         bytes.push_back(sum);
      end
      foreach (bytes[i]) begin
         if (i == send_at) push_send(8'($urandom_range(0, 255)));
         push_rx(bytes[i]);
      end
   endtask

   // driver
   link_item_type in_flight;
   int unsigned   idle_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_frame_link(in_flight);
            items_accepted++;
         end
         if (req_tvalid && !req_tready) begin
            // transaction still pending, hold it
         end else if (stimulus_items.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (stimulus_items[0].drain && responses_due.size() != 0) begin
            req_tvalid <= 1'b0;
         end else if (idle_left < stimulus_items[0].gap) begin
            idle_left++;
            req_tvalid <= 1'b0;
         end else begin
            in_flight = stimulus_items.pop_front();
            idle_left = 0;
            req_tvalid <= 1'b1;
            req_tdata <= {in_flight.act, in_flight.rx};
            req_tuser <= in_flight.cmd;
         end
      end
   end

   // monitor
   link_result_type want;
   int unsigned     stall_left = 0;
   bit              rsp_quiet = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (responses_due.size() == 0) begin
               report_mismatch("arrived with nothing due, tdata", rsp_tdata, 0);
            end else begin
               want = responses_due.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("kind", rsp_tuser, want.kind);
               if (rsp_tdata[7:0] !== want.tx_byte)
                  report_mismatch("tx_byte", rsp_tdata[7:0], want.tx_byte);
               if (rsp_tlast !== want.tx_last)
                  report_mismatch("tx_last", rsp_tlast, want.tx_last);
               if (rsp_tdata[10:8] !== want.st.cover_state)
                  report_mismatch("cover_state", rsp_tdata[10:8], want.st.cover_state);
               if (rsp_tdata[11] !== want.st.aux_relay)
                  report_mismatch("aux_relay", rsp_tdata[11], want.st.aux_relay);
               if (rsp_tdata[12] !== want.st.light_on)
                  report_mismatch("light_on", rsp_tdata[12], want.st.light_on);
               if (rsp_tdata[13] !== want.st.error_flag)
                  report_mismatch("error_flag", rsp_tdata[13], want.st.error_flag);
               if (rsp_tdata[14] !== want.st.venting)
                  report_mismatch("venting", rsp_tdata[14], want.st.venting);
               if (rsp_tdata[15] !== want.st.prewarn)
                  report_mismatch("prewarn", rsp_tdata[15], want.st.prewarn);
               if (rsp_tdata[16] !== want.status_valid)
                  report_mismatch("status_valid", rsp_tdata[16], want.status_valid);
               if (rsp_tdata[23:17] !== 7'd0)
                  report_mismatch("padding", rsp_tdata[23:17], 0);
            end
            results_seen++;
            stall_left = rsp_quiet ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0) rsp_quiet = !rsp_quiet;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   int         total_items;
   int         random_start;
   int         noise_items;
   int         pick;
   int         send_at;
   logic [7:0] p0;
   logic [7:0] pb;

   initial begin
      // directed: hunting noise, send extremes, sync inside payload with a send
      // mid-frame, oversize length, bad checksum, other frame type with extra payload
      push_rx(8'h00);
      push_rx(8'hFF);
      push_send(8'h00);
      push_send(8'hFF);
      queue_frame(slsfl_pkg::STATUS_CMD, slsfl_pkg::STATUS_LEN, slsfl_pkg::FRAME_SYNC,
                  8'h01, 1'b0, 4);
      queue_frame(slsfl_pkg::STATUS_CMD, 8'h10, 8'h00, 8'h00, 1'b0, -1);
      queue_frame(slsfl_pkg::STATUS_CMD, slsfl_pkg::STATUS_LEN, 8'hFE, 8'hFE, 1'b1, -1);
      queue_frame(8'h07, 8'h03, 8'h60, 8'h80, 1'b0, -1);

      random_start = stimulus_items.size();
      noise_items = 0;
      drain_next = 1'b1;
      while (stimulus_items.size() - noise_items - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 39) == 0) quiet_run = !quiet_run;
         if ($urandom_range(0, 59) == 0) drain_next = 1'b1;
         send_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : -1;
         p0 = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 4))
            0: p0[0] = 1'b1;
            1: p0[1:0] = 2'b10;
            2: begin
               p0[1:0] = 2'b00;
               p0[6:5] = 2'b10;
            end
            3: begin
               p0[1:0] = 2'b00;
               p0[6:5] = 2'b11;
            end
            default: begin
               p0[1:0] = 2'b00;
               p0[6] = 1'b0;
            end
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            queue_frame(slsfl_pkg::STATUS_CMD, slsfl_pkg::STATUS_LEN, p0,
                        8'($urandom_range(0, 255)), 1'b0, send_at);
         end else if (pick < 60) begin
            queue_frame(slsfl_pkg::STATUS_CMD, slsfl_pkg::STATUS_LEN, p0,
                        8'($urandom_range(0, 255)), 1'b1, send_at);
         end else if (pick < 70) begin
            queue_frame(8'($urandom_range(0, 255)),
                        8'(($urandom_range(0, 3) == 0)
                           ? $urandom_range(0, slsfl_pkg::MAX_PAYLOAD)
                           : $urandom_range(0, 4)),
                        p0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        send_at);
         end else if (pick < 75) begin
            queue_frame(8'($urandom_range(0, 255)),
                        8'($urandom_range(slsfl_pkg::MAX_PAYLOAD + 1, 255)),
                        8'h00, 8'h00, 1'b0, send_at);
         end else if (pick < 87) begin
            push_send(8'($urandom_range(0, 255)));
         end else begin
            pb = 8'($urandom_range(0, 255));
            if (pb == slsfl_pkg::FRAME_SYNC) pb = ~pb;
            noise_items++;
            push_rx(pb);
         end
      end
      total_items = stimulus_items.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < total_items) @(posedge clock);
      while (responses_due.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/slsfl_pkg.sv
hw/rtl/slsfl_rx_parser.sv
hw/rtl/sync_length_sum_frame_link_unit.sv
tb/tb_sync_length_sum_frame_link_unit.sv
